// ===== rtl/lbc_pkg.sv =====
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared types and constants of the LED blink controller.
// ----------------------------------------------------------------------------
package lbc_pkg;

  localparam int          OUT_W        = 24;
  localparam int          CMD_IDX_W    = 6;       // enough for 64 LEDs
  localparam logic [15:0] HB_RELOAD_RST = 16'd300;
  localparam logic [7:0]  KEEP_FOREVER = 8'hFF;

  // input request codes
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_SET  = 1'b1;

  // queued command codes
  localparam logic [1:0] OP_NOP  = 2'd0;   // set with an index beyond the LEDs
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_SET  = 2'd2;

  typedef struct packed {
    logic [1:0]           op;
    logic [CMD_IDX_W-1:0] idx;
    logic [7:0]           on_time;
    logic [7:0]           off_ticks;
    logic [7:0]           keep_count;
  } cmd_t;

  // per-LED state held in the back end's memory
  typedef struct packed {
    logic [7:0] on_set;
    logic [7:0] off_set;
    logic [7:0] keep;
    logic [7:0] dark_cnt;
    logic [7:0] lit_cnt;
  } led_ent_t;

endpackage

// ===== rtl/lbc_front.sv =====
// ----------------------------------------------------------------------------
// lbc_front
// Accepts request beats, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module lbc_front import lbc_pkg::*; #(
  parameter int NUM_LEDS = 24
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       req_type,
  input  logic [4:0] led_index,
  input  logic [7:0] on_time,
  input  logic [7:0] off_ticks,
  input  logic [7:0] keep_count,
  output logic       q_valid,
  output cmd_t       q_cmd,
  input  logic       q_take
);

  cmd_t       slot [2];
  cmd_t       cmd_in;
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  logic [6:0] idx_ext;

  assign idx_ext = 7'(led_index);

  always_comb begin
    cmd_in.idx        = CMD_IDX_W'(led_index);
    cmd_in.on_time    = on_time;
    cmd_in.off_ticks  = off_ticks;
    cmd_in.keep_count = keep_count;
    if (req_type == REQ_SET) begin
      cmd_in.op = (idx_ext < 7'(NUM_LEDS)) ? OP_SET : OP_NOP;
    end else begin
      cmd_in.op = OP_TICK;
    end
  end

  assign in_stall = (cnt == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt != 2'd0);
  assign q_cmd    = slot[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (q_take) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(q_take);
    end
  end

endmodule

// ===== rtl/lbc_back.sv =====
// ----------------------------------------------------------------------------
// lbc_back
// Executes queued commands: set writes, and the heartbeat plus a pipelined
// walk over the per-LED state memory for ticks. Holds the result register.
// ----------------------------------------------------------------------------
module lbc_back import lbc_pkg::*; #(
  parameter int NUM_LEDS = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [15:0]       heartbeat_reload,
  input  logic              q_valid,
  input  cmd_t              q_cmd,
  output logic              q_take,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [OUT_W-1:0]  led_pattern
);

  localparam int LW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int CW = $clog2(NUM_LEDS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]          state;
  logic [CW-1:0]       icnt;
  logic                s1_v;
  logic [LW-1:0]       s1_idx;
  logic                hb;
  logic [15:0]         prescale;
  logic [NUM_LEDS-1:0] pattern;
  logic [NUM_LEDS-1:0] phase;
  logic [NUM_LEDS-1:0] vld;
  logic [63:0]         pat_wide;

  led_ent_t            mem [NUM_LEDS];
  led_ent_t            rd_data;
  logic                rd_ok;
  logic [LW-1:0]       rd_addr;
  logic                issue;
  logic                we;
  logic [LW-1:0]       waddr;
  led_ent_t            wdata;

  led_ent_t            ent;
  logic [7:0]          keep_n;
  logic [7:0]          dc_n;
  logic [7:0]          lc_n;
  logic                ph_n;
  logic                bit_n;
  logic                out_free;
  logic                out_load;
  logic                last;
  logic                is_set;

  assign out_free = !out_valid || !out_stall;
  assign is_set   = (q_cmd.op == OP_SET);
  assign q_take   = (state == ST_IDLE) && q_valid && ((q_cmd.op == OP_TICK) || out_free);
  assign issue    = (state == ST_SCAN) && (icnt != CW'(NUM_LEDS));
  assign rd_addr  = icnt[LW-1:0];
  assign last     = s1_v && (s1_idx == LW'(NUM_LEDS - 1));
  assign pat_wide = 64'(pattern);
  // set and ignored set beats leave the pattern as it is
  assign out_load = ((state == ST_IDLE) && q_take && (q_cmd.op != OP_TICK)) ||
                    ((state == ST_DONE) && out_free);

  // per-LED update for one scan step
  always_comb begin
    ent    = rd_ok ? rd_data : '0;
    keep_n = ent.keep;
    if (hb && (ent.keep != 8'd0) && (ent.keep != KEEP_FOREVER)) begin
      keep_n = ent.keep - 8'd1;
    end
    ph_n  = phase[s1_idx];
    dc_n  = ent.dark_cnt;
    lc_n  = ent.lit_cnt;
    bit_n = pattern[s1_idx];
    if (ent.on_set == 8'd1 && ent.off_set == 8'd1) begin
      ph_n = 1'b1;
      lc_n = 8'd0;
      dc_n = 8'd1;
    end
    if (ent.on_set == 8'd0 && ent.off_set == 8'd0) begin
      ph_n = 1'b0;
      lc_n = 8'd1;
      dc_n = 8'd0;
    end
    if (keep_n == 8'd0) begin
      ph_n  = 1'b0;
      bit_n = 1'b1;
    end else if (!ph_n) begin
      if (dc_n == 8'd0) begin
        dc_n  = ent.off_set;
        ph_n  = 1'b1;
        bit_n = 1'b1;
      end else begin
        dc_n = dc_n - 8'd1;
      end
    end else begin
      if (lc_n == 8'd0) begin
        lc_n  = ent.on_set;
        ph_n  = 1'b0;
        bit_n = 1'b0;
      end else begin
        lc_n = lc_n - 8'd1;
      end
    end
  end

  // memory write port: set beats from idle, scan write-back otherwise
  always_comb begin
    we    = 1'b0;
    waddr = s1_idx;
    wdata = '{on_set: ent.on_set, off_set: ent.off_set, keep: keep_n,
              dark_cnt: dc_n, lit_cnt: lc_n};
    if (q_take && is_set) begin
      we    = 1'b1;
      waddr = q_cmd.idx[LW-1:0];
      wdata = '{on_set: q_cmd.on_time, off_set: q_cmd.off_ticks,
                keep: q_cmd.keep_count, dark_cnt: q_cmd.off_ticks,
                lit_cnt: q_cmd.on_time};
    end else if (s1_v) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    s1_idx <= rd_addr;
    if (rst) begin
      state       <= ST_IDLE;
      icnt        <= '0;
      s1_v        <= 1'b0;
      hb          <= 1'b0;
      prescale    <= '0;
      pattern     <= '1;
      phase       <= '0;
      vld         <= '0;
      rd_ok       <= 1'b0;
      out_valid   <= 1'b0;
      led_pattern <= '0;
    end else begin
      rd_ok <= vld[rd_addr];
      if (we) vld[waddr] <= 1'b1;
      if (out_load) begin
        out_valid   <= 1'b1;
        led_pattern <= pat_wide[OUT_W-1:0];
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          s1_v <= 1'b0;
          if (q_take && (q_cmd.op == OP_TICK)) begin
            hb       <= (prescale == 16'd0);
            prescale <= (prescale == 16'd0) ? heartbeat_reload : prescale - 16'd1;
            icnt     <= '0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          s1_v <= issue;
          if (issue) icnt <= icnt + CW'(1);
          if (s1_v) begin
            phase[s1_idx]   <= ph_n;
            pattern[s1_idx] <= bit_n;
          end
          if (last) state <= ST_DONE;
        end
        ST_DONE: begin
          s1_v <= 1'b0;
          if (out_free) state <= ST_IDLE;
        end
        default: begin
          s1_v  <= 1'b0;
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/led_blink_controller_core.sv =====
// Tick path: with the queue empty, an accepted tick beat leaves the queue, fills the read
// pipeline, takes one walk step per LED through the state memory's single read port, and
// then loads the result register. A set beat leaves the queue and loads the result
// register directly. Output stalls delay the result. The back end takes no new beat
// while a tick walk runs; the two-entry queue holds beats and stalls input when full.
// Reset (rst, synchronous): all LEDs dark, state cleared, reload = 300.
// ----------------------------------------------------------------------------
// led_blink_controller_core
// Blink engine for active-low LEDs with a shared heartbeat prescaler.
// ----------------------------------------------------------------------------
module led_blink_controller_core import lbc_pkg::*; #(
  parameter int NUM_LEDS = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [15:0]      cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             req_type,
  input  logic [4:0]       led_index,
  input  logic [7:0]       on_time,
  input  logic [7:0]       off_ticks,
  input  logic [7:0]       keep_count,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [OUT_W-1:0] led_pattern
);

  logic [15:0] heartbeat_reload;
  logic        q_valid;
  cmd_t        q_cmd;
  logic        q_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      heartbeat_reload <= HB_RELOAD_RST;
    end else if (cfg_valid && cfg_ready) begin
      heartbeat_reload <= cfg_data;
    end
  end

  lbc_front #(.NUM_LEDS(NUM_LEDS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .led_index  (led_index),
    .on_time    (on_time),
    .off_ticks  (off_ticks),
    .keep_count (keep_count),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_take     (q_take)
  );

  lbc_back #(.NUM_LEDS(NUM_LEDS)) u_back (
    .clk              (clk),
    .rst              (rst),
    .heartbeat_reload (heartbeat_reload),
    .q_valid          (q_valid),
    .q_cmd            (q_cmd),
    .q_take           (q_take),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .led_pattern      (led_pattern)
  );

endmodule

// ===== rtl/lbc_checker.sv =====
// ----------------------------------------------------------------------------
// lbc_checker
// Port-level checks of the LED blink controller, bound to the top level.
// ----------------------------------------------------------------------------
module lbc_checker import lbc_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [OUT_W-1:0] led_pattern
);

  // beats in flight: queue, back end and result register hold at most four
  logic [3:0] pending;
  logic       acc_in;
  logic       acc_out;

  assign acc_in  = in_valid && !in_stall;
  assign acc_out = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 4'(acc_in) - 4'(acc_out);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(led_pattern))
    else $error("result changed while stalled");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 4'd0)
    else $error("result without an accepted request");

  a_cap: assert property (@(posedge clk) disable iff (rst)
    pending <= 4'd4)
    else $error("more beats in flight than the design holds");

endmodule

bind led_blink_controller_core lbc_checker u_lbc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .led_pattern (led_pattern)
);
